[rtl/vttc_pkg.sv]
// Package for the visual target tracking controller.
// Types, register indexes and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vttc_pkg;

    localparam int TICK_MS_DEF = 50;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int Q_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK      = 3'd4;

    localparam logic [1:0] M_SEARCH = 2'd0;
    localparam logic [1:0] M_TRACK  = 2'd1;
    localparam logic [1:0] M_SEQ    = 2'd2;

    typedef struct packed {
        logic signed [7:0] target_x;
        logic signed [7:0] target_y;
        logic [7:0]        target_size;
    } t_in;

    typedef struct packed {
        logic [1:0]        mode;
        logic              chassis_valid;
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic              arm_valid;
        logic signed [7:0] arm_drive;
        logic              hand_valid;
        logic signed [7:0] hand_angle;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        t_in         item;
        logic        found;     // size > min_size
        logic        near;      // size < zero_size/3
    } t_cls;

endpackage
`default_nettype wire

[rtl/visual_target_tracking_controller_core.sv]
// Visual target tracking controller, top level: registers, front, back.
// From input accept to output beat: queue write, pop, then four errors, each a
// setup step plus a 15-step bit-serial divide when an error is neither saturated
// nor zero, then S_FIN forms the beat and S_OUT hands it out.
// The back takes one beat at a time and holds it on output stall; reset (synchronous,
// active low) restores registers to defaults, search mode. Needs vttc_front/back.
`timescale 1ns / 1ps
`default_nettype none
module visual_target_tracking_controller_core
    import vttc_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  t_in                  i_data,
    output logic                 o_valid,
    input  wire                  i_stall,
    output t_out                 o_data,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);
    logic signed [7:0] r_zx, r_zy;
    logic [7:0]        r_zs, r_ms;
    logic [9:0]        r_lt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zx <= '0; r_zy <= '0; r_zs <= 8'd50; r_ms <= 8'd5; r_lt <= 10'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ZERO_X:    r_zx <= i_cfg_data[7:0];
                REG_ZERO_Y:    r_zy <= i_cfg_data[7:0];
                REG_ZERO_SIZE: r_zs <= i_cfg_data[7:0];
                REG_MIN_SIZE:  r_ms <= i_cfg_data[7:0];
                REG_LOCK:      r_lt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic q_valid, q_pop;
    t_cls q_data;

    vttc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .i_min_size(r_ms), .i_zero_size(r_zs),
        .o_valid(q_valid), .i_pop(q_pop), .o_data(q_data)
    );

    vttc_back #(.TICK_MS(TICK_MS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .o_pop(q_pop),
        .i_data(q_data), .i_zero_x(r_zx), .i_zero_y(r_zy), .i_zero_size(r_zs),
        .i_lock_ticks(r_lt), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

[rtl/vttc_front.sv]
// Front: accepts beats, classifies them and pushes them into a short queue.
// Depends on vttc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vttc_front
    import vttc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  t_in        i_data,
    input  wire [7:0]  i_min_size,
    input  wire [7:0]  i_zero_size,
    output logic       o_valid,
    input  wire        i_pop,
    output t_cls       o_data
);
    localparam int PW = $clog2(Q_DEPTH);

    t_cls           r_q [Q_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;
    logic           push;
    t_cls           cls;
    logic [7:0]     third;

    // zero_size/3 via reciprocal: (v*171)>>9 exact for v<256
    assign third = 8'(({8'd0, i_zero_size} * 16'd171) >> 9);

    always_comb begin
        cls.item  = i_data;
        cls.found = i_data.target_size > i_min_size;
        cls.near  = i_data.target_size < third;
    end

    assign o_stall = r_cnt == (PW+1)'(Q_DEPTH);
    assign push    = i_valid && !o_stall;
    assign o_valid = r_cnt != '0;
    assign o_data  = r_q[r_rp];

    // queue storage and pointers
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cls;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= PW'((r_wp + 1'b1) % Q_DEPTH);
            if (i_pop) r_rp <= PW'((r_rp + 1'b1) % Q_DEPTH);
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/vttc_back.sv]
// Back: mode sequencer, proportional errors and drive commands.
// Iterates a shared proportional error step; depends on vttc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vttc_back
    import vttc_pkg::*;
#(
    parameter int TICK_MS = TICK_MS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_pop,
    input  t_cls             i_data,
    input  wire signed [7:0] i_zero_x,
    input  wire signed [7:0] i_zero_y,
    input  wire [7:0]        i_zero_size,
    input  wire [9:0]        i_lock_ticks,
    output logic             o_valid,
    input  wire              i_stall,
    output t_out             o_data
);
    localparam int T_TURN = (500 + TICK_MS - 1) / TICK_MS;
    localparam int T_DROP = (2500 + TICK_MS - 1) / TICK_MS;
    localparam int T_BACK = (3000 + TICK_MS - 1) / TICK_MS;
    localparam int T_DONE = (5000 + TICK_MS - 1) / TICK_MS;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_FIN, S_OUT} t_st;

    t_st               r_st;
    logic [1:0]        r_mode;
    logic              r_cen, r_lock;
    logic [9:0]        r_lcnt;
    logic [12:0]       r_seq;
    t_cls              r_it;
    logic [1:0]        r_k;          // which error: 0 x,1 y,2 size,3 speed
    logic signed [8:0] r_e [4];
    t_out              r_out;
    logic              r_fire;
    // restoring divider state
    logic [14:0]       r_num;
    logic [8:0]        r_den;
    logic [14:0]       r_quo;
    logic [3:0]        r_bit;
    logic              r_neg;

    // operand setup for error k
    logic signed [9:0] v, z, lo, hi;
    logic signed [9:0] dz;
    logic [8:0]        dmag;
    always_comb begin
        unique case (r_k)
            2'd0: begin v = 10'(r_it.item.target_x); z = 10'(i_zero_x); lo = -10'sd100; end
            2'd1: begin v = 10'(r_it.item.target_y); z = 10'(i_zero_y); lo = -10'sd100; end
            2'd2: begin v = {2'b0, r_it.item.target_size}; z = {2'b0, i_zero_size};
                        lo = 10'sd0; end
            default: begin v = {2'b0, r_it.item.target_size};
                        z = {2'b0, i_zero_size} + 10'sd10; lo = 10'sd0; end
        endcase
        hi = 10'sd100;
        dz = v - z;
        dmag = 9'((dz < 0) ? -dz : dz);
    end

    logic [9:0] lim;
    assign lim = (i_lock_ticks == '0) ? 10'd1 : i_lock_ticks;

    // final drive math; 3x/10 by reciprocal 205/2048, exact for |3x| <= 384
    logic signed [9:0]  yaw, sp, l, r;
    logic signed [10:0] y3;
    logic [8:0]         ymag;
    logic [17:0]        yprod;
    always_comb begin
        y3    = 11'(r_it.item.target_x) * 11'sd3;
        ymag  = 9'((y3 < 0) ? -y3 : y3);
        yprod = 18'(ymag) * 18'd205;
        yaw   = (y3 < 0) ? -10'(yprod[17:11]) : 10'(yprod[17:11]);
        sp    = 10'(r_e[3]);
        l     = (yaw - sp) / 10'sd2;
        r     = (-sp - yaw) / 10'sd2;
    end
    function automatic logic signed [7:0] bias(input logic signed [9:0] a);
        bias = 8'(a + ((a > 0) ? 10'sd5 : (a < 0) ? -10'sd5 : 10'sd0));
    endfunction
    function automatic logic small_err(input logic signed [8:0] e);
        small_err = (e <= 9'sd10) && (e >= -9'sd10);
    endfunction

    assign o_pop   = (r_st == S_IDLE) && i_valid;
    assign o_valid = r_st == S_OUT;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_mode <= M_SEARCH; r_cen <= 1'b1; r_lock <= 1'b0;
            r_lcnt <= '0; r_seq <= '0; r_k <= '0; r_fire <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_it <= i_data;
                    r_out <= '0;
                    r_fire <= 1'b0;
                    if (r_mode == 2'd3) r_mode <= M_SEARCH;
                    r_k <= '0;
                    r_bit <= 4'd0;
                    r_st <= S_DIV;
                    if (r_lock) begin
                        if (r_lcnt + 10'd1 >= lim) begin
                            r_lock <= 1'b0; r_lcnt <= '0; r_fire <= 1'b1;
                        end else r_lcnt <= r_lcnt + 10'd1;
                    end
                end
                // one error per pass; a bit of quotient per cycle
                S_DIV: begin
                    if (r_bit == 4'd0) begin
                        if (dz > 0 && v >= hi) begin
                            r_e[r_k] <= 9'sd100; r_bit <= 4'd0;
                            r_k <= r_k + 2'd1; if (r_k == 2'd3) r_st <= S_FIN;
                        end else if (dz < 0 && v <= lo) begin
                            r_e[r_k] <= -9'sd100;
                            r_k <= r_k + 2'd1; if (r_k == 2'd3) r_st <= S_FIN;
                        end else if (dz == 0) begin
                            r_e[r_k] <= 9'sd0;
                            r_k <= r_k + 2'd1; if (r_k == 2'd3) r_st <= S_FIN;
                        end else begin
                            r_neg <= dz < 0;
                            r_num <= 15'(dmag) * 15'd100;
                            r_den <= 9'(dz > 0 ? hi - z : z - lo);
                            r_quo <= '0;
                            r_bit <= 4'd15;
                        end
                    end else begin
                        logic [15:0] rem;
                        rem = 16'(r_num >> (r_bit - 4'd1));
                        if (rem >= {7'd0, r_den}) begin
                            r_num <= r_num - 15'({6'd0, r_den} << (r_bit - 4'd1));
                            r_quo[r_bit - 4'd1] <= 1'b1;
                        end
                        r_bit <= r_bit - 4'd1;
                        if (r_bit == 4'd1) begin
                            logic [14:0] q;
                            q = r_quo | ((rem >= {7'd0, r_den}) ? 15'd1 : 15'd0);
                            r_e[r_k] <= r_neg ? -9'(q) : 9'(q);
                            r_k <= r_k + 2'd1; if (r_k == 2'd3) r_st <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_st <= S_OUT;
                    if (r_fire) begin
                        r_mode <= M_SEQ; r_seq <= '0;
                        r_out.chassis_valid <= 1'b1; r_out.arm_valid <= 1'b1;
                        r_out.hand_valid <= 1'b1; r_out.hand_angle <= 8'sd90;
                        r_out.mode <= M_SEQ;
                    end else if (r_mode == M_TRACK) begin
                        if (!r_it.found) begin
                            r_mode <= M_SEARCH; r_out.mode <= M_SEARCH;
                        end else begin
                            r_out.mode <= M_TRACK;
                            r_out.chassis_valid <= 1'b1; r_out.arm_valid <= 1'b1;
                            if (r_cen || r_it.near) begin
                                r_out.left_drive <= bias(l);
                                r_out.right_drive <= bias(r);
                            end
                            r_out.arm_drive <= 8'(-r_e[1]);
                            r_cen <= small_err(r_e[1]);
                            if (small_err(r_e[0]) && small_err(r_e[1]) && small_err(r_e[2])) begin
                                if (!r_lock) begin r_lock <= 1'b1; r_lcnt <= '0; end
                            end else begin
                                r_lock <= 1'b0; r_lcnt <= '0;
                            end
                        end
                    end else if (r_mode == M_SEQ) begin
                        logic [12:0] t;
                        t = r_seq + 13'd1;
                        if (32'(t) >= T_DONE) begin
                            r_mode <= M_SEARCH; r_seq <= '0; r_out.mode <= M_SEARCH;
                        end else begin
                            r_seq <= t; r_out.mode <= M_SEQ;
                            if (32'(t) == T_TURN) begin
                                r_out.arm_valid <= 1'b1; r_out.arm_drive <= 8'sd60;
                                r_out.chassis_valid <= 1'b1;
                                r_out.left_drive <= -8'sd30; r_out.right_drive <= 8'sd30;
                            end
                            if (32'(t) == T_DROP) begin
                                r_out.arm_valid <= 1'b1; r_out.arm_drive <= 8'sd0;
                                r_out.chassis_valid <= 1'b1;
                                r_out.left_drive <= 8'sd0; r_out.right_drive <= 8'sd0;
                                r_out.hand_valid <= 1'b1; r_out.hand_angle <= -8'sd90;
                            end
                            if (32'(t) == T_BACK) begin
                                r_out.chassis_valid <= 1'b1;
                                r_out.left_drive <= 8'sd30; r_out.right_drive <= -8'sd30;
                            end
                        end
                    end else begin
                        if (r_it.found) begin
                            r_mode <= M_TRACK; r_out.mode <= M_TRACK;
                        end else begin
                            r_out.mode <= M_SEARCH; r_out.chassis_valid <= 1'b1;
                            r_out.left_drive <= -8'sd20; r_out.right_drive <= 8'sd20;
                        end
                    end
                end
                S_OUT: if (!i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
